// ===== rtl/ism_pkg.sv =====
// Shared types and constants for the interval sort and merge block.
`default_nettype none
package ism_pkg;
  localparam int unsigned CoordW  = 31;
  localparam int unsigned MaxIntervals = 64;
  localparam int unsigned CntW   = $clog2(MaxIntervals + 1);
  localparam int unsigned QDepth = 2;

  typedef struct packed {
    logic [CoordW-1:0] interval_start;
    logic [CoordW-1:0] interval_stop;
    logic              last_in_set;
  } in_item_t;

  typedef struct packed {
    logic [CoordW-1:0] merged_start;
    logic [CoordW-1:0] merged_stop;
    logic              last_merged;
    logic              overflowed;
  } out_item_t;

  // Front-end classification handed to the back end.
  typedef struct packed {
    logic [CoordW-1:0] start;
    logic [CoordW-1:0] stop;
    logic              store;
    logic              last;
  } cmd_t;
endpackage
`default_nettype wire

// ===== rtl/ism_front.sv =====
// Front end: accept items, classify keep or drop, queue commands.
`default_nettype none
module ism_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ism_pkg::in_item_t in_data_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output ism_pkg::cmd_t        cmd_o,
  output logic                 cmd_valid_o,
  input  wire logic            cmd_ready_i
);
  import ism_pkg::*;

  cmd_t              q_mem_q [QDepth];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        fill_q;
  logic [CntW-1:0]   kept_q;
  logic              push, pop;
  cmd_t              cmd;

  assign in_ready_o  = (fill_q != 2'(QDepth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  // Classify: keep while the set has room.
  always_comb begin
    cmd.start = in_data_i.interval_start;
    cmd.stop  = in_data_i.interval_stop;
    cmd.last  = in_data_i.last_in_set;
    cmd.store = (kept_q < CntW'(MaxIntervals));
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_ptr_q] <= cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
      kept_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
        if (in_data_i.last_in_set) kept_q <= '0;
        else if (cmd.store) kept_q <= kept_q + CntW'(1);
      end
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ism_back.sv =====
// Back end: sorted insertion chain, then merge walk and emission.
`default_nettype none
module ism_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [ism_pkg::CoordW-1:0] gap_i,
  input  wire ism_pkg::cmd_t     cmd_i,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_ready_o,
  output ism_pkg::out_item_t     out_data_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i
);
  import ism_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_MERGE = 3'b010,
    ST_SHIFT = 3'b100
  } state_e;

  state_e            state_q;
  logic [CoordW-1:0] st_q [MaxIntervals];
  logic [CoordW-1:0] sp_q [MaxIntervals];
  logic [CntW-1:0]   cnt_q;
  logic              ovf_q;
  logic [CntW-1:0]   walk_q;
  logic              grp_q;
  logic [CoordW-1:0] gs_q, ge_q;
  out_item_t         out_q;
  logic              out_v_q;
  logic [MaxIntervals-1:0] gt;
  logic [CoordW:0]   reach;
  logic              joins, take, emit;

  // One comparator per cell: does this held start exceed the new start.
  always_comb begin
    for (int k = 0; k < MaxIntervals; k++) begin
      gt[k] = (CntW'(k) < cnt_q) && (st_q[k] > cmd_i.start);
    end
  end

  assign cmd_ready_o = (state_q == ST_LOAD);
  assign take        = cmd_valid_i && cmd_ready_o;
  assign out_data_o  = out_q;
  assign out_valid_o = out_v_q;

  assign reach = {1'b0, ge_q} + {1'b0, gap_i};
  assign joins = (walk_q < cnt_q) && ({1'b0, st_q[0]} <= reach);
  assign emit  = (state_q == ST_MERGE) && grp_q && !joins && (!out_v_q || out_ready_i);

  // Insert chain: cells above the slot shift up.
  always_ff @(posedge clk_i) begin
    if (take && cmd_i.store) begin
      for (int k = 0; k < MaxIntervals; k++) begin
        if (gt[k] && (k + 1 < MaxIntervals)) begin
          st_q[(k + 1) % MaxIntervals] <= st_q[k];
          sp_q[(k + 1) % MaxIntervals] <= sp_q[k];
        end
        // Write the new interval into the first cell above it, or the first free one.
        if (((k == 0) || !gt[(k + MaxIntervals - 1) % MaxIntervals]) &&
            (gt[k] || (CntW'(k) == cnt_q))) begin
          st_q[k] <= cmd_i.start;
          sp_q[k] <= cmd_i.stop;
        end
      end
    end else if (state_q == ST_MERGE && (!grp_q || joins || emit) && walk_q < cnt_q) begin
      // Drain the head: shift the chain down one.
      for (int k = 0; k + 1 < MaxIntervals; k++) begin
        st_q[k] <= st_q[k + 1];
        sp_q[k] <= sp_q[k + 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      walk_q  <= '0;
      grp_q   <= 1'b0;
      gs_q    <= '0;
      ge_q    <= '0;
      out_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      case (state_q)
        ST_LOAD: begin
          if (take) begin
            if (cmd_i.store) cnt_q <= cnt_q + CntW'(1);
            else ovf_q <= 1'b1;
            if (cmd_i.last) begin
              state_q <= ST_MERGE;
              walk_q  <= '0;
              grp_q   <= 1'b0;
            end
          end
        end
        ST_MERGE: begin
          if (!grp_q) begin
            if (walk_q < cnt_q) begin
              gs_q   <= st_q[0];
              ge_q   <= sp_q[0];
              grp_q  <= 1'b1;
              walk_q <= walk_q + CntW'(1);
            end else begin
              state_q <= ST_LOAD;
              cnt_q   <= '0;
              ovf_q   <= 1'b0;
            end
          end else if (joins) begin
            if (sp_q[0] > ge_q) ge_q <= sp_q[0];
            walk_q <= walk_q + CntW'(1);
          end else if (emit) begin
            out_q.merged_start <= gs_q;
            out_q.merged_stop  <= ge_q;
            out_q.last_merged  <= (walk_q >= cnt_q);
            out_q.overflowed   <= ovf_q;
            out_v_q <= 1'b1;
            if (walk_q < cnt_q) begin
              gs_q   <= st_q[0];
              ge_q   <= sp_q[0];
              walk_q <= walk_q + CntW'(1);
            end else begin
              grp_q   <= 1'b0;
              state_q <= ST_SHIFT;
            end
          end
        end
        ST_SHIFT: begin
          state_q <= ST_LOAD;
          cnt_q   <= '0;
          ovf_q   <= 1'b0;
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/interval_sort_and_merge.sv =====
// Items pass through the front-end queue into the sorted chain; after the last
// item of a set the merge walk runs over the held intervals, with results one beat
// per merged interval. Throughput: one item per cycle while loading; loading of
// the next set waits for the walk over the held entries. Reset clears counts,
// flags, the queue and gap tolerance; stored intervals are not cleared.
// Top level: configuration register, front end and back end.
`default_nettype none
module interval_sort_and_merge (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [ism_pkg::CoordW-1:0] cfg_wdata_i,
  input  wire ism_pkg::in_item_t  in_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output ism_pkg::out_item_t      out_data_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i
);
  import ism_pkg::*;

  logic [CoordW-1:0] gap_q;
  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  // Hold the gap tolerance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gap_q <= '0;
    else if (cfg_we_i) gap_q <= cfg_wdata_i;
  end

  ism_front u_front (
    .clk_i, .rst_ni, .in_data_i, .in_valid_i, .in_ready_o,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready)
  );

  ism_back u_back (
    .clk_i, .rst_ni, .gap_i(gap_q), .cmd_i(cmd), .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready), .out_data_o, .out_valid_o, .out_ready_i
  );
endmodule
`default_nettype wire

// ===== rtl/ism_checker.sv =====
// Port-level checks for the interval sort and merge block, with bind.
`default_nettype none
module ism_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire ism_pkg::out_item_t out_data_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i
);
  import ism_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_no_reset_out: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  a_ovf_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_merged ##1 out_valid_o
    |-> out_data_o.overflowed == $past(out_data_o.overflowed))
    else $error("overflow flag changed within a set");
endmodule

bind interval_sort_and_merge ism_checker u_ism_checker (
  .clk_i, .rst_ni, .out_data_o, .out_valid_o, .out_ready_i
);
`default_nettype wire
